// ===== design/pizc_pkg.sv =====
// Shared types, constants and codes of the incremental PID zone controller.
package pizc_pkg;

    // Field widths fixed by the stream and register formats.
    localparam int TEMP_W     = 16;
    localparam int CLAMP_W    = 14;
    localparam int ERR_W      = 15;
    localparam int GAIN_W     = 16;
    localparam int THR_W      = 14;
    localparam int DUTY_W     = 10;
    localparam int ZONE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Width of one PID increment: three gain products of up to 34 bits summed.
    localparam int DELTA_W = 36;

    // Default arithmetic format of the accumulator.
    localparam int DEF_GAIN_FRAC_BITS = 8;
    localparam int DEF_ACC_WIDTH      = 41;

    // Clamp limits of the setpoint and the measurement.
    localparam logic [TEMP_W-1:0] SP_LOW    = 16'd1000;
    localparam logic [TEMP_W-1:0] TEMP_HIGH = 16'd10000;

    // Output zone codes.
    localparam logic [ZONE_W-1:0] ZONE_FULL_ON  = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_REGULATE = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_FULL_OFF = 2'd2;
    localparam logic [ZONE_W-1:0] ZONE_HOLD     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN = 3'd6;

    // Register reset values.
    localparam logic [GAIN_W-1:0] RST_GAIN_P   = 16'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = 16'd26;
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = 16'd0;
    localparam logic [THR_W-1:0]  RST_ERR_HIGH = 14'd400;
    localparam logic [THR_W-1:0]  RST_ERR_LOW  = 14'd0;
    localparam logic [DUTY_W-1:0] RST_DUTY_MAX = 10'd1000;
    localparam logic [DUTY_W-1:0] RST_DUTY_MIN = 10'd0;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [THR_W-1:0]  err_high;
        logic [THR_W-1:0]  err_low;
        logic [DUTY_W-1:0] duty_max;
        logic [DUTY_W-1:0] duty_min;
    } t_cfg;

    // Error and zone decision of one sample.
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic [ZONE_W-1:0]       zone;
    } t_err_info;

endpackage

// ===== design/pizc_cfg.sv =====
// Configuration register file of the incremental PID zone controller.
module pizc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [pizc_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [pizc_pkg::CFG_DATA_W-1:0]   i_data,
    output pizc_pkg::t_cfg                    o_cfg
);

    pizc_pkg::t_cfg r_cfg;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p   <= pizc_pkg::RST_GAIN_P;
            r_cfg.gain_i   <= pizc_pkg::RST_GAIN_I;
            r_cfg.gain_d   <= pizc_pkg::RST_GAIN_D;
            r_cfg.err_high <= pizc_pkg::RST_ERR_HIGH;
            r_cfg.err_low  <= pizc_pkg::RST_ERR_LOW;
            r_cfg.duty_max <= pizc_pkg::RST_DUTY_MAX;
            r_cfg.duty_min <= pizc_pkg::RST_DUTY_MIN;
        end else if (i_valid) begin
            case (i_index)
                pizc_pkg::CFG_GAIN_P:   r_cfg.gain_p   <= i_data;
                pizc_pkg::CFG_GAIN_I:   r_cfg.gain_i   <= i_data;
                pizc_pkg::CFG_GAIN_D:   r_cfg.gain_d   <= i_data;
                pizc_pkg::CFG_ERR_HIGH: r_cfg.err_high <= i_data[pizc_pkg::THR_W-1:0];
                pizc_pkg::CFG_ERR_LOW:  r_cfg.err_low  <= i_data[pizc_pkg::THR_W-1:0];
                pizc_pkg::CFG_DUTY_MAX: r_cfg.duty_max <= i_data[pizc_pkg::DUTY_W-1:0];
                pizc_pkg::CFG_DUTY_MIN: r_cfg.duty_min <= i_data[pizc_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/pizc_zone.sv =====
// Input clamping, control error and zone decision.
module pizc_zone (
    input  logic [pizc_pkg::TEMP_W-1:0] i_set_point,
    input  logic [pizc_pkg::TEMP_W-1:0] i_measured,
    input  pizc_pkg::t_cfg              i_cfg,
    output pizc_pkg::t_err_info         o_info
);

    logic [pizc_pkg::TEMP_W-1:0]         sp_clamped;
    logic [pizc_pkg::TEMP_W-1:0]         ms_clamped;
    logic signed [pizc_pkg::ERR_W-1:0]   err;
    logic signed [pizc_pkg::ERR_W-1:0]   thr_high;
    logic signed [pizc_pkg::ERR_W-1:0]   thr_low;

    // Clamp the setpoint to its band and the measurement to its ceiling.
    always_comb begin
        sp_clamped = i_set_point;
        if (i_set_point < pizc_pkg::SP_LOW) begin
            sp_clamped = pizc_pkg::SP_LOW;
        end
        if (i_set_point > pizc_pkg::TEMP_HIGH) begin
            sp_clamped = pizc_pkg::TEMP_HIGH;
        end
        ms_clamped = i_measured;
        if (i_measured > pizc_pkg::TEMP_HIGH) begin
            ms_clamped = pizc_pkg::TEMP_HIGH;
        end
    end

    // Both clamped values fit in 14 bits, so the difference fits in 15 signed bits.
    assign err = $signed({1'b0, sp_clamped[pizc_pkg::CLAMP_W-1:0]})
               - $signed({1'b0, ms_clamped[pizc_pkg::CLAMP_W-1:0]});
    assign thr_high = $signed({1'b0, i_cfg.err_high});
    assign thr_low  = $signed({1'b0, i_cfg.err_low});

    // Zone tests in priority order: full on, regulating band, full off, hold.
    always_comb begin
        o_info.err = err;
        if (err > thr_high) begin
            o_info.zone = pizc_pkg::ZONE_FULL_ON;
        end else if (err > thr_low && err < thr_high) begin
            o_info.zone = pizc_pkg::ZONE_REGULATE;
        end else if (err < 0) begin
            o_info.zone = pizc_pkg::ZONE_FULL_OFF;
        end else begin
            o_info.zone = pizc_pkg::ZONE_HOLD;
        end
    end

endmodule

// ===== design/pizc_pid.sv =====
// Velocity-form PID state, saturating accumulator and duty selection.
module pizc_pid #(
    parameter int GAIN_FRAC_BITS = pizc_pkg::DEF_GAIN_FRAC_BITS,
    parameter int ACC_WIDTH      = pizc_pkg::DEF_ACC_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  pizc_pkg::t_err_info           i_info,
    input  pizc_pkg::t_cfg                i_cfg,
    output logic [pizc_pkg::DUTY_W-1:0]   o_duty
);

    localparam int ERR_W  = pizc_pkg::ERR_W;
    localparam int DUTY_W = pizc_pkg::DUTY_W;
    localparam int DW     = pizc_pkg::DELTA_W;
    localparam int SW     = ((ACC_WIDTH > DW) ? ACC_WIDTH : DW) + 1;
    localparam int CW     = ((ACC_WIDTH > DUTY_W + GAIN_FRAC_BITS) ?
                             ACC_WIDTH : DUTY_W + GAIN_FRAC_BITS) + 1;
    localparam logic signed [SW-1:0] ACC_HI =
        {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

    logic signed [ACC_WIDTH-1:0] r_accum;
    logic signed [ERR_W-1:0]     r_err_prev;
    logic signed [ERR_W-1:0]     r_err_prev2;
    logic [DUTY_W-1:0]           r_last_duty;

    logic signed [ACC_WIDTH-1:0] n_accum;
    logic signed [ERR_W:0]       diff_p;
    logic signed [ERR_W+1:0]     diff_d;
    logic signed [32:0]          prod_p;
    logic signed [31:0]          prod_i;
    logic signed [33:0]          prod_d;
    logic signed [DW-1:0]        delta;
    logic signed [SW-1:0]        acc_sum;
    logic signed [CW-1:0]        acc_c;
    logic signed [CW-1:0]        lo_c;
    logic signed [CW-1:0]        whole_c;
    logic signed [CW-1:0]        max_c;
    logic [DUTY_W-1:0]           pid_duty;
    logic                        regulate;

    assign regulate = i_step && (i_info.zone == pizc_pkg::ZONE_REGULATE);

    // Error differences for the proportional and derivative terms.
    assign diff_p = $signed({i_info.err[ERR_W-1], i_info.err})
                  - $signed({r_err_prev[ERR_W-1], r_err_prev});
    assign diff_d = $signed({{2{i_info.err[ERR_W-1]}}, i_info.err})
                  - $signed({r_err_prev[ERR_W-1], r_err_prev, 1'b0})
                  + $signed({{2{r_err_prev2[ERR_W-1]}}, r_err_prev2});

    // Three independent gain products, summed into one increment.
    assign prod_p = $signed({1'b0, i_cfg.gain_p}) * diff_p;
    assign prod_i = $signed({1'b0, i_cfg.gain_i}) * i_info.err;
    assign prod_d = $signed({1'b0, i_cfg.gain_d}) * diff_d;
    assign delta  = $signed({{(DW - 33){prod_p[32]}}, prod_p})
                  + $signed({{(DW - 32){prod_i[31]}}, prod_i})
                  + $signed({{(DW - 34){prod_d[33]}}, prod_d});

    // Saturating accumulate at the signed accumulator range.
    always_comb begin
        acc_sum = $signed({{(SW - ACC_WIDTH){r_accum[ACC_WIDTH-1]}}, r_accum})
                + $signed({{(SW - DW){delta[DW-1]}}, delta});
        if (acc_sum > ACC_HI) begin
            n_accum = ACC_HI[ACC_WIDTH-1:0];
        end else if (acc_sum < ACC_LO) begin
            n_accum = ACC_LO[ACC_WIDTH-1:0];
        end else begin
            n_accum = acc_sum[ACC_WIDTH-1:0];
        end
    end

    // Integer part of the new accumulator, limited to the duty range.
    always_comb begin
        acc_c   = $signed({{(CW - ACC_WIDTH){n_accum[ACC_WIDTH-1]}}, n_accum});
        lo_c    = $signed({{(CW - DUTY_W - GAIN_FRAC_BITS){1'b0}}, i_cfg.duty_min,
                           {GAIN_FRAC_BITS{1'b0}}});
        whole_c = acc_c >>> GAIN_FRAC_BITS;
        max_c   = $signed({{(CW - DUTY_W){1'b0}}, i_cfg.duty_max});
        if (acc_c < lo_c) begin
            pid_duty = i_cfg.duty_min;
        end else if (whole_c > max_c) begin
            pid_duty = i_cfg.duty_max;
        end else begin
            pid_duty = whole_c[DUTY_W-1:0];
        end
    end

    // Output duty by zone.
    always_comb begin
        case (i_info.zone)
            pizc_pkg::ZONE_FULL_ON:  o_duty = i_cfg.duty_max;
            pizc_pkg::ZONE_REGULATE: o_duty = pid_duty;
            pizc_pkg::ZONE_FULL_OFF: o_duty = i_cfg.duty_min;
            default:                 o_duty = r_last_duty;
        endcase
    end

    // State moves only on processed samples; the PID history only when regulating.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_err_prev  <= '0;
            r_err_prev2 <= '0;
            r_last_duty <= '0;
        end else if (i_step) begin
            if (regulate) begin
                r_accum     <= n_accum;
                r_err_prev2 <= r_err_prev;
                r_err_prev  <= i_info.err;
            end
            if (i_info.zone != pizc_pkg::ZONE_HOLD) begin
                r_last_duty <= o_duty;
            end
        end
    end

    // The accumulator moves only on a regulating step.
    a_accum_only_regulate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_accum != $past(r_accum))) |-> $past(regulate))
        else $error("accumulator changed outside a regulating step");

    // The error history shifts together.
    a_history_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(regulate) |-> (r_err_prev2 == $past(r_err_prev)))
        else $error("error history did not shift");

    // Only positive errors reach the regulating band, so the history is never negative.
    a_history_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_err_prev[ERR_W-1] && !r_err_prev2[ERR_W-1])
        else $error("negative error stored in history");

endmodule

// ===== design/incremental_pid_zone_controller.sv =====
// Incremental PID heater controller with error zones: stream top level.
//
// Each transfer on the slave stream carries one setpoint and one measured
// temperature and produces exactly one result transfer with a duty value and
// a zone code. The block takes one sample per clock cycle as long as the result
// stream takes its results. Each sample is captured in the input register and
// moves on to the result register once that register is free (input register,
// then result register). The slave side keeps accepting while a result waits
// to be taken as long as the input register is empty. The rate is set by the
// update loop through the accumulator and the two stored errors: three gain
// products, one sum and a saturating add per sample.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while no sample is in flight.
module incremental_pid_zone_controller #(
    parameter int GAIN_FRAC_BITS = pizc_pkg::DEF_GAIN_FRAC_BITS,
    parameter int ACC_WIDTH      = pizc_pkg::DEF_ACC_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample stream in.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // [15:0] set_point, [31:16] measured
    // Result stream out.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // [9:0] duty, [11:10] zone, rest zero
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pizc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pizc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int TEMP_W = pizc_pkg::TEMP_W;
    localparam int DUTY_W = pizc_pkg::DUTY_W;
    localparam int ZONE_W = pizc_pkg::ZONE_W;

    logic                    r_in_valid;
    logic [TEMP_W-1:0]       r_set_point;
    logic [TEMP_W-1:0]       r_measured;
    logic                    r_out_valid;
    logic [DUTY_W-1:0]       r_duty;
    logic [ZONE_W-1:0]       r_zone;

    logic                    out_free;
    logic                    advance;
    logic                    in_take;
    pizc_pkg::t_cfg          cfg;
    pizc_pkg::t_err_info     info;
    logic [DUTY_W-1:0]       duty;

    // Handshake: the input register drains into the result register when it is free.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    pizc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_set_point <= s_axis_tdata[TEMP_W-1:0];
            r_measured  <= s_axis_tdata[2*TEMP_W-1:TEMP_W];
        end
    end

    pizc_zone u_zone (
        .i_set_point (r_set_point),
        .i_measured  (r_measured),
        .i_cfg       (cfg),
        .o_info      (info)
    );

    pizc_pid #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .ACC_WIDTH      (ACC_WIDTH)
    ) u_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_info  (info),
        .i_cfg   (cfg),
        .o_duty  (duty)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_duty <= duty;
            r_zone <= info.zone;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_zone, r_duty};

    // A new result only appears after a sample sat in the input register.
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_in_valid))
        else $error("result produced without a pending sample");

    // The slave side stalls only when both registers are full and the result is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("slave side stalled without a full pipeline");

    // A pending sample moves on whenever the result register is taken or empty.
    a_no_lost_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free && !in_take) |=> !r_in_valid)
        else $error("input register did not drain");

endmodule
